// ===== src/oal_pkg.sv =====
// shared constants, codes and types of the ordered array list
`timescale 1ns / 1ps

package oal_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W  = 8;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic [KEY_BITS-1:0]     entry_key;
        logic [PAYLOAD_BITS-1:0] entry_payload;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  found_position;
        logic [CNT_W-1:0]  list_length;
    } res_t;

endpackage

// ===== src/oal_if.sv =====
// request and response channel interfaces of the ordered array list
`timescale 1ns / 1ps

interface oal_req_if;
    logic                                valid;
    logic                                ready;
    logic [oal_pkg::REQ_W-1:0]           req_type;
    logic [oal_pkg::POS_W-1:0]           position;
    logic [oal_pkg::KEY_BITS-1:0]        entry_key;
    logic [oal_pkg::PAYLOAD_BITS-1:0]    entry_payload;

    modport source (output valid, req_type, position, entry_key, entry_payload,
                    input ready);
    modport sink   (input valid, req_type, position, entry_key, entry_payload,
                    output ready);
endinterface

interface oal_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [oal_pkg::STAT_W-1:0]    status;
    logic [oal_pkg::CNT_W-1:0]     found_position;
    logic [oal_pkg::CNT_W-1:0]     list_length;

    modport source (output valid, status, found_position, list_length,
                    input ready);
    modport sink   (input valid, status, found_position, list_length,
                    output ready);
endinterface

// ===== src/oal_store.sv =====
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module oal_store (
    input  logic              clk,
    input  oal_pkg::mem_cmd_t cmd,
    output oal_pkg::entry_t   rd_data
);
    import oal_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/oal_seq.sv =====
// sequencer: range checks, entry shift walk and key search over the memory
`timescale 1ns / 1ps

module oal_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  oal_pkg::req_t     req,
    output logic              res_valid,
    input  logic              res_ready,
    output oal_pkg::res_t     res,
    output oal_pkg::mem_cmd_t cmd,
    input  oal_pkg::entry_t   rd_data
);
    import oal_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_RESP} state_t;

    state_t                  state_reg, state_next;
    logic [REQ_W-1:0]        op_reg, op_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        dst_reg, dst_next;
    logic [IDX_W-1:0]        put_reg, put_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic                    pend_reg, pend_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    res_t                    res_reg, res_next;

    logic [CMP_W-1:0] ext_pos;
    logic [CMP_W-1:0] ext_cnt;

    assign ext_pos = CMP_W'(req.position);
    assign ext_cnt = CMP_W'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        cur_next     = cur_reg;
        dst_next     = dst_reg;
        put_next     = put_reg;
        left_next    = left_reg;
        pend_next    = pend_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        res_next     = res_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next                 = req.req_type;
                    key_next                = req.entry_key;
                    payload_next            = req.entry_payload;
                    put_next                = IDX_W'(ext_pos - 1'b1);
                    pend_next               = 1'b0;
                    res_next.status         = ST_DONE;
                    res_next.found_position = '0;
                    res_next.list_length    = count_reg;
                    state_next              = S_RESP;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else if (ext_pos == '0 || ext_pos > ext_cnt + 1'b1)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                // walk from the last entry down to the slot
                                cur_next   = IDX_W'(ext_cnt - 1'b1);
                                left_next  = CNT_W'(ext_cnt - ext_pos + 1'b1);
                                state_next = S_WALK;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (ext_pos == '0 || ext_pos > ext_cnt)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                // walk from the entry after the hole up to the end
                                cur_next   = IDX_W'(ext_pos);
                                left_next  = CNT_W'(ext_cnt - ext_pos);
                                state_next = S_WALK;
                            end
                        end
                        REQ_LOCATE:
                        begin
                            cur_next   = '0;
                            left_next  = count_reg;
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            res_next.status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (pend_reg && op_reg == REQ_LOCATE && rd_data.key == key_reg)
                begin
                    res_next.status         = ST_DONE;
                    res_next.found_position = CNT_W'(dst_reg) + 1'b1;
                    pend_next               = 1'b0;
                    state_next              = S_RESP;
                end
                else
                begin
                    // move the entry read last cycle
                    if (pend_reg && op_reg != REQ_LOCATE)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = dst_reg;
                        cmd.wr_data = rd_data;
                    end
                    if (left_reg != '0)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = cur_reg;
                        left_next   = left_reg - 1'b1;
                        pend_next   = 1'b1;
                        case (op_reg)
                            REQ_INSERT:
                            begin
                                dst_next = cur_reg + 1'b1;
                                cur_next = cur_reg - 1'b1;
                            end
                            REQ_DELETE:
                            begin
                                dst_next = cur_reg - 1'b1;
                                cur_next = cur_reg + 1'b1;
                            end
                            default:
                            begin
                                dst_next = cur_reg;
                                cur_next = cur_reg + 1'b1;
                            end
                        endcase
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            state_next = S_RESP;
                            case (op_reg)
                                REQ_INSERT:
                                begin
                                    cmd.wr_en               = 1'b1;
                                    cmd.wr_addr             = put_reg;
                                    cmd.wr_data.key         = key_reg;
                                    cmd.wr_data.payload     = payload_reg;
                                    count_next              = count_reg + 1'b1;
                                    res_next.status         = ST_DONE;
                                    res_next.list_length    = count_reg + 1'b1;
                                end
                                REQ_DELETE:
                                begin
                                    count_next              = count_reg - 1'b1;
                                    res_next.status         = ST_DONE;
                                    res_next.list_length    = count_reg - 1'b1;
                                end
                                default:
                                begin
                                    res_next.status         = ST_MISSING;
                                    res_next.found_position = '0;
                                end
                            endcase
                        end
                    end
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= REQ_INSERT;
            cur_reg     <= '0;
            dst_reg     <= '0;
            put_reg     <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            key_reg     <= '0;
            payload_reg <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            cur_reg     <= cur_next;
            dst_reg     <= dst_next;
            put_reg     <= put_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            key_reg     <= key_next;
            payload_reg <= payload_next;
            res_reg     <= res_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

endmodule

// ===== src/ordered_array_list.sv =====
// top level of the ordered array list
`timescale 1ns / 1ps

// ordered_array_list: bounded ordered list of key/payload entries
//
// channels
//   req  : one request per transfer (insert, delete or locate by key)
//   rsp  : exactly one result per request: status, found position and the
//          list length after the request, in request order
//
// timing
//   a request is taken only while the sequencer is idle; one entry moves or
//   is compared per cycle through the entry memory (one read and one write
//   port), which sets the rate.
//
// reset
//   the list length clears at once; memory contents are not cleared and are
//   only read below the current length, so no clearing pass is needed
//
// back pressure
//   results sit in an output register; the next request is accepted while a
//   result waits there, and its own result then holds until rsp drains

module ordered_array_list (
    input  logic      clk,
    input  logic      rst_n,
    oal_req_if.sink   req,
    oal_rsp_if.source rsp
);
    import oal_pkg::*;

    req_t     seq_req;
    res_t     seq_res;
    logic     seq_res_valid;
    logic     seq_res_ready;
    mem_cmd_t mem_cmd;
    entry_t   mem_rd_data;

    // output register
    logic     out_valid_reg, out_valid_next;
    res_t     out_res_reg, out_res_next;

    assign seq_req.req_type      = req.req_type;
    assign seq_req.position      = req.position;
    assign seq_req.entry_key     = req.entry_key;
    assign seq_req.entry_payload = req.entry_payload;

    oal_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (seq_req),
        .res_valid (seq_res_valid),
        .res_ready (seq_res_ready),
        .res       (seq_res),
        .cmd       (mem_cmd),
        .rd_data   (mem_rd_data)
    );

    oal_store u_store (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (mem_rd_data)
    );

    // load a new result when the register is empty or being drained
    assign seq_res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (seq_res_valid && seq_res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = seq_res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_res_reg.status;
    assign rsp.found_position = out_res_reg.found_position;
    assign rsp.list_length    = out_res_reg.list_length;

endmodule

// ===== src/oal_checker.sv =====
// port-level assertions for the ordered array list, bound to the top level
`timescale 1ns / 1ps

module oal_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [oal_pkg::STAT_W-1:0]   status,
    input logic [oal_pkg::CNT_W-1:0]    found_position,
    input logic [oal_pkg::CNT_W-1:0]    list_length
);
    import oal_pkg::*;

    // a held result keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(found_position) && $stable(list_length))
        else $error("result changed while stalled");

    // the sequencer is busy in the cycle after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // the length never passes capacity, and full is reported only at capacity
    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> list_length <= CNT_W'(MAX_ENTRIES)
            && (status != ST_FULL || list_length == CNT_W'(MAX_ENTRIES)))
        else $error("bad list length");

    // a found position lies inside the list and comes with a done status
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found_position != '0 |->
            status == ST_DONE && found_position <= list_length)
        else $error("bad found position");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .found_position (rsp.found_position),
    .list_length    (rsp.list_length)
);
